FILE: hw/rtl/sphere_box_clipped_volume_assert.svh
// ============================================================================
// Assertion macros for the sphere and box clipped volume block
// Concurrent checks on clk with rst_n held low as a disable; empty in synthesis.
// ============================================================================
`ifndef SPHERE_BOX_CLIPPED_VOLUME_ASSERT_SVH
`define SPHERE_BOX_CLIPPED_VOLUME_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge out of reset.
`define SBCV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never occurs out of reset.
`define SBCV_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SBCV_ASSERT(label, prop, msg)
`define SBCV_NEVER(label, cond, msg)
`endif
`endif

FILE: hw/rtl/sbcv_pkg.sv
// ============================================================================
// sbcv_pkg
// Shared types and codes for the sphere and box clipped volume block.
// ============================================================================
`timescale 1ns / 1ps

package sbcv_pkg;

  // Default sizing.
  localparam int MAX_CELLS_DEF  = 32;
  localparam int COORD_BITS_DEF = 32;

  // Register reset values and the volume saturation limit.
  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [30:0] MESH_RST   = 31'd4096;
  localparam logic [30:0] FULLV_RST  = 31'd274517;
  localparam logic [30:0] VOL_SAT    = 31'h7FFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SHAPE  = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_MESH   = 2'd2,
    CFG_FULLV  = 2'd3
  } cfg_idx_t;

  // Result classification codes.
  typedef enum logic [2:0] {
    CASE_OUTSIDE  = 3'd0,
    CASE_INSIDE   = 3'd1,
    CASE_PARTIAL  = 3'd2,
    CASE_TOO_MANY = 3'd3,
    CASE_NOT_SPH  = 3'd4
  } case_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_CLS, S_SNAP, S_SNAP_B1, S_SNAP_B2, S_SNAP_C, S_NCNT, S_NCHK,
    S_THR, S_INIT, S_HMUL, S_HACC, S_NEXT, S_V0, S_V1, S_V2, S_V3, S_V4, S_V5,
    S_CENT, S_CENT_R, S_DIV, S_FINISH
  } state_t;

endpackage

FILE: hw/rtl/sphere_box_clipped_volume.sv
// ============================================================================
// sphere_box_clipped_volume
// Volume and centroid of the part of a sphere that lies inside a box.
// ============================================================================
// An item skips the snap and the cell walk when the sphere is wholly outside
// or inside the box, or when the shape is not a sphere. In the partial case the
// box is snapped per axis with up to nine divisions (two for the snap and one
// for the cell count on each axis), then every mesh cell is tested: a cell takes
// at most one multiply and one accumulate per axis on the single 32x32
// multiplier, plus the step. The walk is followed by five multiplies for the
// volume and three divisions for the centroid. Each division runs on the shared
// restoring divider at one quotient bit per cycle over a dividend of 40 bits plus
// the width of the hit count, which is 56 bits with the default sizing. The block
// accepts no item until the current one is finished; a result waits in the
// output register while the next item is taken.
`timescale 1ns / 1ps

`include "sphere_box_clipped_volume_assert.svh"

module sphere_box_clipped_volume
  import sbcv_pkg::*;
#(
  parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
  parameter int COORD_BITS         = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_box_low_x,
  input  logic signed [31:0] in_box_low_y,
  input  logic signed [31:0] in_box_low_z,
  input  logic signed [31:0] in_box_high_x,
  input  logic signed [31:0] in_box_high_y,
  input  logic signed [31:0] in_box_high_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        out_inside_volume,
  output logic signed [31:0] out_centroid_x,
  output logic signed [31:0] out_centroid_y,
  output logic signed [31:0] out_centroid_z,
  output logic [2:0]         out_overlap_case
);

  localparam int CW    = 40;
  localparam int CNT_W = $clog2(MAX_CELLS_PER_AXIS ** 3 + 1);
  localparam int NC_W  = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int SUM_W = CW + CNT_W;
  localparam int DVD_W = SUM_W;
  localparam int DVS_W = 33;
  localparam int DC_W  = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CELLS_PER_AXIS ** 3);
  localparam logic signed [DVD_W:0] SAT_HI =
    {{(DVD_W + 2 - COORD_BITS){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [DVD_W:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic        shape_r;
  logic [30:0] radius_r, mesh_r, fullv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= 1'b1;
      radius_r <= RADIUS_RST;
      mesh_r   <= MESH_RST;
      fullv_r  <= FULLV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SHAPE:  shape_r  <= cfg_data[0];
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_MESH:   mesh_r   <= cfg_data;
        CFG_FULLV:  fullv_r  <= cfg_data;
        default:    shape_r  <= shape_r;
      endcase
    end
  end

  state_t state_r, state_nxt, ret_r;

  logic signed [CW-1:0] p_r [3];
  logic signed [CW-1:0] lo_r [3];
  logic signed [CW-1:0] hi_r [3];
  logic signed [CW-1:0] t2b_r [3];
  logic signed [CW-1:0] t2c_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic [NC_W-1:0]      n_r [3];
  logic [NC_W-1:0]      idx_r [3];
  logic [1:0]           ax_r;
  logic                 outf_r, inf_r, neg_r;
  logic [65:0]          s_r;
  logic [63:0]          thr_r, prod_r, sq_r, p1_r, t1_r;
  logic [31:0]          f_r;
  logic [CNT_W-1:0]     count_r;
  logic [30:0]          vol_r;
  logic [31:0]          cen_r [3];
  case_t                case_r;

  // Shared divider registers.
  logic [DVD_W-1:0] dvd_r, dq_r;
  logic [DVS_W-1:0] dden_r, drem_r;
  logic [DC_W-1:0]  dcnt_r;

  // Per-axis views and the conditions the sequencer tests.
  logic signed [CW-1:0] r_ext, m_ext, pa, la, ha, pmr, ppr, dd, dcell, ad;
  assign r_ext = {{(CW - 31){1'b0}}, radius_r};
  assign m_ext = {{(CW - 31){1'b0}}, mesh_r};
  assign pa    = p_r[ax_r];
  assign la    = lo_r[ax_r];
  assign ha    = hi_r[ax_r];
  assign pmr   = pa - r_ext;
  assign ppr   = pa + r_ext;
  assign dd    = (ha - la) <<< 1;
  assign dcell = t2c_r[ax_r] - (pa <<< 1);
  assign ad    = (dcell < 0) ? -dcell : dcell;

  logic outside_a, inside_a, lo_lt, lo_lt2, hi_gt, n_zero, far, last_cell, hit;
  logic [65:0] snew;
  logic [63:0] q_c, total_c;
  assign outside_a = (la > ppr) || (ha < pmr);
  assign inside_a  = (la <= pmr) && (ha >= ppr);
  assign lo_lt     = la < pmr;
  assign lo_lt2    = la < ppr;
  assign hi_gt     = ha > ppr;
  assign n_zero    = dd <= m_ext;
  assign far       = ad >= (r_ext <<< 1);
  assign snew      = s_r + {2'b00, prod_r};
  assign hit       = snew < {2'b00, thr_r};
  assign last_cell = (idx_r[0] + 1'b1 == n_r[0]) && (idx_r[1] + 1'b1 == n_r[1]) &&
                     (idx_r[2] + 1'b1 == n_r[2]);
  assign q_c       = p1_r + {32'd0, prod_r[63:32]};
  assign total_c   = t1_r + {32'd0, prod_r[63:32]};

  // Divider step and remainder-corrected results.
  logic [DVS_W:0]   dsh;
  logic [DVS_W+1:0] dtrial;
  logic signed [CW-1:0] rem_ext, fl_c;
  logic signed [DVD_W:0] cq;
  assign dsh     = {drem_r, dq_r[DVD_W-1]};
  assign dtrial  = {1'b0, dsh} - {2'b00, dden_r};
  assign rem_ext = {{(CW - DVS_W){1'b0}}, drem_r};
  assign fl_c    = signed'(dvd_r[CW-1:0]) - rem_ext;
  assign cq      = neg_r ? (-signed'({1'b0, dq_r}) - {{DVD_W{1'b0}}, (drem_r != '0)})
                         : signed'({1'b0, dq_r});

  // Operand widening for the divider.
  logic [DVD_W-1:0] num1, num3, num4;
  logic [SUM_W-1:0] sum_mag;
  assign num1    = {{(DVD_W - CW){1'b0}}, pmr - la};
  assign num3    = {{(DVD_W - CW){1'b0}}, ppr - la};
  assign num4    = {{(DVD_W - CW){1'b0}}, dd + m_ext - 1'b1};
  assign sum_mag = (sum_r[ax_r] < 0) ? unsigned'(-sum_r[ax_r]) : unsigned'(sum_r[ax_r]);

  // Shared multiplier; the product is registered every cycle.
  logic [31:0] mul_a, mul_b, cnt32;
  assign cnt32 = {{(32 - CNT_W){1'b0}}, count_r};
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_HMUL: begin mul_a = ad[31:0];              mul_b = ad[31:0];         end
      S_THR:  begin mul_a = {radius_r, 1'b0};     mul_b = {radius_r, 1'b0}; end
      S_V0:   begin mul_a = {1'b0, mesh_r};       mul_b = {1'b0, mesh_r};   end
      S_V1:   begin mul_a = prod_r[63:32];        mul_b = {1'b0, mesh_r};   end
      S_V2:   begin mul_a = sq_r[31:0];           mul_b = {1'b0, mesh_r};   end
      S_V3:   begin mul_a = cnt32;                mul_b = q_c[31:0];        end
      S_V4:   begin mul_a = cnt32;                mul_b = f_r;              end
      default: begin mul_a = 32'd0;               mul_b = 32'd0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign in_ready = (state_r == S_IDLE);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = shape_r ? S_CLS : S_FINISH;
      S_CLS: begin
        if (ax_r == 2'd2) begin
          if (outf_r || outside_a)                      state_nxt = S_FINISH;
          else if (inf_r && inside_a)                   state_nxt = S_FINISH;
          else if (mesh_r == '0)                        state_nxt = S_FINISH;
          else                                          state_nxt = S_SNAP;
        end
      end
      S_SNAP: begin
        if (lo_lt)                state_nxt = S_DIV;
        else if (lo_lt2 && hi_gt) state_nxt = S_DIV;
        else                      state_nxt = S_NCNT;
      end
      S_SNAP_B1: state_nxt = hi_gt ? S_DIV : S_NCNT;
      S_SNAP_B2: state_nxt = S_NCNT;
      S_SNAP_C:  state_nxt = S_NCNT;
      S_NCNT: begin
        if (!n_zero)            state_nxt = S_DIV;
        else if (ax_r == 2'd2)  state_nxt = S_THR;
        else                    state_nxt = S_SNAP;
      end
      S_NCHK: begin
        if (dq_r > DVD_W'(MAX_CELLS_PER_AXIS)) state_nxt = S_FINISH;
        else if (ax_r == 2'd2)                 state_nxt = S_THR;
        else                                   state_nxt = S_SNAP;
      end
      S_THR:  state_nxt = S_INIT;
      S_INIT: state_nxt = ((n_r[0] == '0) || (n_r[1] == '0) || (n_r[2] == '0)) ?
                          S_FINISH : S_HMUL;
      S_HMUL: state_nxt = far ? S_NEXT : S_HACC;
      S_HACC: state_nxt = (ax_r == 2'd2) ? S_NEXT : S_HMUL;
      S_NEXT: begin
        if (!last_cell)          state_nxt = S_HMUL;
        else if (count_r == '0)  state_nxt = S_FINISH;
        else                     state_nxt = S_V0;
      end
      S_V0: state_nxt = S_V1;
      S_V1: state_nxt = S_V2;
      S_V2: state_nxt = S_V3;
      S_V3: state_nxt = (q_c > 64'(VOL_SAT)) ? S_CENT : S_V4;
      S_V4: state_nxt = S_V5;
      S_V5: state_nxt = S_CENT;
      S_CENT:   state_nxt = S_DIV;
      S_CENT_R: state_nxt = (ax_r == 2'd2) ? S_FINISH : S_CENT;
      S_DIV:    if (dcnt_r == DC_W'(1)) state_nxt = ret_r;
      S_FINISH: if (!out_valid || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and divider.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p_r[0]  <= CW'(in_center_x);
          p_r[1]  <= CW'(in_center_y);
          p_r[2]  <= CW'(in_center_z);
          lo_r[0] <= CW'(in_box_low_x);
          lo_r[1] <= CW'(in_box_low_y);
          lo_r[2] <= CW'(in_box_low_z);
          hi_r[0] <= CW'(in_box_high_x);
          hi_r[1] <= CW'(in_box_high_y);
          hi_r[2] <= CW'(in_box_high_z);
          ax_r    <= 2'd0;
          outf_r  <= 1'b0;
          inf_r   <= 1'b1;
          vol_r   <= '0;
          cen_r[0] <= '0;
          cen_r[1] <= '0;
          cen_r[2] <= '0;
          case_r  <= shape_r ? CASE_OUTSIDE : CASE_NOT_SPH;
        end
      end
      // Outside and inside tests, one axis a cycle.
      S_CLS: begin
        outf_r <= outf_r | outside_a;
        inf_r  <= inf_r & inside_a;
        ax_r   <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          if (outf_r || outside_a) begin
            case_r <= CASE_OUTSIDE;
          end else if (inf_r && inside_a) begin
            case_r   <= CASE_INSIDE;
            vol_r    <= fullv_r;
            cen_r[0] <= p_r[0][31:0];
            cen_r[1] <= p_r[1][31:0];
            cen_r[2] <= p_r[2][31:0];
          end else if (mesh_r == '0) begin
            case_r <= CASE_TOO_MANY;
          end
        end
      end
      // Snap the box to the mesh on this axis.
      S_SNAP: begin
        if (lo_lt) begin
          dvd_r <= num1; dq_r <= num1; dden_r <= {2'b00, mesh_r};
          drem_r <= '0; dcnt_r <= DC_W'(DVD_W); ret_r <= S_SNAP_B1;
        end else if (lo_lt2 && hi_gt) begin
          dvd_r <= num3; dq_r <= num3; dden_r <= {2'b00, mesh_r};
          drem_r <= '0; dcnt_r <= DC_W'(DVD_W); ret_r <= S_SNAP_C;
        end else if (!lo_lt2) begin
          hi_r[ax_r] <= la;
        end
      end
      S_SNAP_B1: begin
        lo_r[ax_r] <= la + fl_c;
        if (hi_gt) begin
          dvd_r <= {{(DVD_W - 32){1'b0}}, radius_r, 1'b0};
          dq_r  <= {{(DVD_W - 32){1'b0}}, radius_r, 1'b0};
          dden_r <= {2'b00, mesh_r};
          drem_r <= '0; dcnt_r <= DC_W'(DVD_W); ret_r <= S_SNAP_B2;
        end
      end
      S_SNAP_B2: hi_r[ax_r] <= la + fl_c + m_ext;
      S_SNAP_C:  hi_r[ax_r] <= la + fl_c + m_ext;
      // Cell count on this axis.
      S_NCNT: begin
        if (!n_zero) begin
          dvd_r <= num4; dq_r <= num4; dden_r <= {1'b0, mesh_r, 1'b0};
          drem_r <= '0; dcnt_r <= DC_W'(DVD_W); ret_r <= S_NCHK;
        end else begin
          n_r[ax_r] <= '0;
          ax_r      <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_NCHK: begin
        if (dq_r > DVD_W'(MAX_CELLS_PER_AXIS)) begin
          case_r <= CASE_TOO_MANY;
        end else begin
          n_r[ax_r] <= dq_r[NC_W-1:0];
          ax_r      <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_THR: ax_r <= 2'd0;
      // Start of the cell walk.
      S_INIT: begin
        thr_r   <= prod_r;
        case_r  <= CASE_PARTIAL;
        count_r <= '0;
        s_r     <= '0;
        for (int a = 0; a < 3; a++) begin
          t2b_r[a] <= (lo_r[a] <<< 1) + m_ext;
          t2c_r[a] <= (lo_r[a] <<< 1) + m_ext;
          idx_r[a] <= '0;
          sum_r[a] <= '0;
        end
      end
      S_HACC: begin
        s_r  <= snew;
        ax_r <= ax_r + 2'd1;
        if (ax_r == 2'd2 && hit) begin
          count_r <= count_r + 1'b1;
          for (int a = 0; a < 3; a++) sum_r[a] <= sum_r[a] + SUM_W'(t2c_r[a]);
        end
      end
      // Step to the next cell centre.
      S_NEXT: begin
        s_r  <= '0;
        ax_r <= 2'd0;
        if (idx_r[2] + 1'b1 != n_r[2]) begin
          idx_r[2] <= idx_r[2] + 1'b1;
          t2c_r[2] <= t2c_r[2] + (m_ext <<< 1);
        end else begin
          idx_r[2] <= '0;
          t2c_r[2] <= t2b_r[2];
          if (idx_r[1] + 1'b1 != n_r[1]) begin
            idx_r[1] <= idx_r[1] + 1'b1;
            t2c_r[1] <= t2c_r[1] + (m_ext <<< 1);
          end else begin
            idx_r[1] <= '0;
            t2c_r[1] <= t2b_r[1];
            idx_r[0] <= idx_r[0] + 1'b1;
            t2c_r[0] <= t2c_r[0] + (m_ext <<< 1);
          end
        end
      end
      // Volume: count times the cubed mesh size, scaled down by 2^32.
      S_V1: sq_r <= prod_r;
      S_V2: p1_r <= prod_r;
      S_V3: begin
        f_r <= prod_r[31:0];
        if (q_c > 64'(VOL_SAT)) vol_r <= VOL_SAT;
      end
      S_V4: t1_r <= prod_r;
      S_V5: vol_r <= (total_c > 64'(VOL_SAT)) ? VOL_SAT : total_c[30:0];
      // Centroid: floor of the doubled sum over twice the count.
      S_CENT: begin
        neg_r  <= sum_r[ax_r] < 0;
        dvd_r  <= sum_mag;
        dq_r   <= sum_mag;
        dden_r <= {{(DVS_W - CNT_W - 1){1'b0}}, count_r, 1'b0};
        drem_r <= '0;
        dcnt_r <= DC_W'(DVD_W);
        ret_r  <= S_CENT_R;
      end
      S_CENT_R: begin
        if (cq > SAT_HI)      cen_r[ax_r] <= SAT_HI[31:0];
        else if (cq < SAT_LO) cen_r[ax_r] <= SAT_LO[31:0];
        else                  cen_r[ax_r] <= cq[31:0];
        ax_r <= ax_r + 2'd1;
      end
      // One restoring division step.
      S_DIV: begin
        dcnt_r <= dcnt_r - 1'b1;
        if (!dtrial[DVS_W+1]) begin
          drem_r <= dtrial[DVS_W-1:0];
          dq_r   <= {dq_r[DVD_W-2:0], 1'b1};
        end else begin
          drem_r <= dsh[DVS_W-1:0];
          dq_r   <= {dq_r[DVD_W-2:0], 1'b0};
        end
      end
      default: ax_r <= ax_r;
    endcase
  end

  // Output register.
  logic out_valid_r;
  assign out_valid = out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && (!out_valid_r || out_ready)) begin
      out_inside_volume <= vol_r;
      out_centroid_x    <= cen_r[0];
      out_centroid_y    <= cen_r[1];
      out_centroid_z    <= cen_r[2];
      out_overlap_case  <= case_r;
    end
  end

  // Checks on the sequencer.
  `SBCV_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "item accepted while busy")
  `SBCV_NEVER(a_count_max, (state_r == S_NEXT) && (count_r > CNT_MAX), "hit count exceeds the cell total")
  `SBCV_ASSERT(a_case_code, out_valid |-> (out_overlap_case <= CASE_NOT_SPH), "bad case code")
  `SBCV_ASSERT(a_div_len, (state_r == S_DIV) |-> (dcnt_r != '0), "divider ran past its end")

endmodule
